@@ hw/rtl/polgv_pkg.sv @@
// Shared constants for the polar Gaussian variate generator.
package polgv_pkg;

    localparam int UNIFORM_WIDTH_DEF = 16;
    localparam int LOG_BITS = 24;
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
    localparam logic [22:0] Y_MAX = 23'h7F_FFFF;
    localparam int SQ_OP_W = 40;
    localparam int SQ_ROOT_W = 20;
    localparam int SQ_REM_W = 22;
    localparam int SQ_CNT_W = 5;

endpackage

@@ hw/rtl/polar_gaussian_variate.sv @@
// Polar Box-Muller Gaussian variate generator, top level.
//
//  channel | direction | handshake            | payload
//  in      | input     | i_in_valid/o_in_stall | i_uniform_a, i_uniform_b
//  out     | output    | o_out_valid/i_out_stall | o_sample
//  cfg     | input     | APB psel/penable     | paddr, pwdata, prdata
//
// A pair that yields a variate passes through squaring and range check, normalize shifts
// (up to 2*W-3), 24 logarithm steps, logarithm scaling, 31 divide steps, root start, the
// root and the scaling and output states before the output valid rises. A pair met while
// a variate is pending releases the stored variate through the scaling and output states.
// Rejected pairs return to idle after the range check. Reset clears the pending variate
// and the registers to mean 0 and deviation 1.0. A word stalled at the output holds the
// final step only; the input is taken again once the result is registered.
module polar_gaussian_variate
    import polgv_pkg::*;
#(
    parameter int UNIFORM_WIDTH = UNIFORM_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [UNIFORM_WIDTH-1:0] i_uniform_a,
    input  logic [UNIFORM_WIDTH-1:0] i_uniform_b,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [23:0]              o_sample,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int W  = UNIFORM_WIDTH;
    localparam int FW = 2 * W - 2;
    localparam int KW = $clog2(FW + 1);
    localparam int MW = W + SQ_ROOT_W;

    localparam logic REG_MEAN = 1'b0;
    localparam logic REG_STD  = 1'b1;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SQA  = 5'd1;
    localparam logic [4:0] S_SQB  = 5'd2;
    localparam logic [4:0] S_CHK  = 5'd3;
    localparam logic [4:0] S_NORM = 5'd4;
    localparam logic [4:0] S_LOG  = 5'd5;
    localparam logic [4:0] S_LN   = 5'd6;
    localparam logic [4:0] S_DIV  = 5'd7;
    localparam logic [4:0] S_ROOT = 5'd8;
    localparam logic [4:0] S_SCA  = 5'd9;
    localparam logic [4:0] S_SHA  = 5'd10;
    localparam logic [4:0] S_SCB  = 5'd11;
    localparam logic [4:0] S_SHB  = 5'd12;
    localparam logic [4:0] S_EMUL = 5'd13;
    localparam logic [4:0] S_EOUT = 5'd14;
    localparam logic [4:0] S_RST  = 5'd15;

    logic [4:0]          r_state;
    logic [W-1:0]        r_a_mag;
    logic [W-1:0]        r_b_mag;
    logic                r_a_neg;
    logic                r_b_neg;
    logic [2*W-1:0]      r_w;
    logic [FW-1:0]       r_norm;
    logic [KW-1:0]       r_k;
    logic [31:0]         r_z;
    logic [LOG_BITS-1:0] r_frac;
    logic [4:0]          r_cnt;
    logic [32:0]         r_rem;
    logic [31:0]         r_m;
    logic [31:0]         r_q;
    logic [SQ_ROOT_W-1:0] r_s;
    logic [MW-1:0]       r_mag;
    logic [37:0]         r_emag;
    logic [23:0]         r_stored;
    logic                r_pending;
    logic [23:0]         r_y;
    logic [15:0]         r_mean;
    logic [14:0]         r_std;
    logic                r_out_valid;
    logic [23:0]         r_sample;

    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         prod;
    logic                in_take;
    logic                out_free;
    logic                cfg_wr;
    logic [W:0]          a_neg_v;
    logic [W:0]          b_neg_v;
    logic [FW+31:0]      norm_ext;
    logic [32:0]         z_t;
    logic [KW+LOG_BITS-1:0] l_val;
    logic [33:0]         rem2;
    logic [31:0]         q_adj;
    logic [KW-1:0]       k_adj;
    logic                sq_start;
    logic                sq_done;
    logic [SQ_ROOT_W-1:0] sq_root;
    logic signed [7:0]   sh;
    logic [7:0]          dneg;
    logic [22:0]         lim;
    logic [MW+2:0]       shl;
    logic [MW:0]         rnd;
    logic [MW:0]         shr;
    logic [22:0]         r_sc;
    logic                sc_neg;
    logic [23:0]         y_sc;
    logic [22:0]         y_mag;
    logic [20:0]         e_r;
    logic [25:0]         e_v;
    logic [23:0]         e_sat;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite;
    assign a_neg_v  = (W+1)'(0) - {i_uniform_a[W-1], i_uniform_a};
    assign b_neg_v  = (W+1)'(0) - {i_uniform_b[W-1], i_uniform_b};
    assign norm_ext = {r_norm, 32'd0};
    assign y_mag    = r_y[23] ? 23'(-r_y) : r_y[22:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQA: begin
                mul_a = 32'(r_a_mag);
                mul_b = 32'(r_a_mag);
            end
            S_SQB: begin
                mul_a = 32'(r_b_mag);
                mul_b = 32'(r_b_mag);
            end
            S_LOG: begin
                mul_a = r_z;
                mul_b = r_z;
            end
            S_LN: begin
                mul_a = 32'(l_val);
                mul_b = LN2_Q32;
            end
            S_SCA: begin
                mul_a = 32'(r_a_mag);
                mul_b = 32'(r_s);
            end
            S_SCB: begin
                mul_a = 32'(r_b_mag);
                mul_b = 32'(r_s);
            end
            S_EMUL: begin
                mul_a = 32'(y_mag);
                mul_b = 32'(r_std);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    always_comb begin
        z_t   = prod[63:31];
        l_val = {r_k, LOG_BITS'(0)} - (KW+LOG_BITS)'(r_frac);
        rem2  = {r_rem, 1'b0};
        q_adj = r_k[0] ? {r_q[30:0], 1'b0} : r_q;
        k_adj = r_k[0] ? (r_k - 1'b1) : r_k;
    end

    always_comb begin
        sh     = $signed(8'(r_k >> 1)) + 8'sd3 - $signed(8'(W));
        dneg   = 8'(-sh);
        lim    = Y_MAX >> sh[1:0];
        shl    = (MW+3)'(r_mag) << sh[1:0];
        rnd    = (MW+1)'(1) << (dneg - 8'd1);
        shr    = ((MW+1)'(r_mag) + rnd) >> dneg;
        r_sc   = '0;
        if (!sh[7]) begin
            if (r_mag > MW'(lim)) begin
                r_sc = Y_MAX;
            end else begin
                r_sc = shl[22:0];
            end
        end else begin
            if (shr > (MW+1)'(Y_MAX)) begin
                r_sc = Y_MAX;
            end else begin
                r_sc = shr[22:0];
            end
        end
        sc_neg = (r_state == S_SHA) ? r_a_neg : r_b_neg;
        y_sc   = sc_neg ? (24'd0 - {1'b0, r_sc}) : {1'b0, r_sc};
    end

    always_comb begin
        e_r = 21'((r_emag + 38'd131072) >> 18);
        if (r_y[23]) begin
            e_v = {{10{r_mean[15]}}, r_mean} - {5'd0, e_r};
        end else begin
            e_v = {{10{r_mean[15]}}, r_mean} + {5'd0, e_r};
        end
        if (!e_v[25] && (e_v[24:23] != 2'b00)) begin
            e_sat = 24'h7F_FFFF;
        end else if (e_v[25] && (e_v[24:23] != 2'b11)) begin
            e_sat = 24'h80_0000;
        end else begin
            e_sat = e_v[23:0];
        end
    end

    assign sq_start = (r_state == S_RST);

    polgv_isqrt u_isqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sq_start),
        .i_operand ({q_adj, 8'd0}),
        .o_done    (sq_done),
        .o_root    (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= 1'b0;
            r_stored    <= '0;
            r_mean      <= '0;
            r_std       <= 15'd256;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    REG_MEAN: r_mean <= pwdata[15:0];
                    REG_STD:  r_std  <= pwdata[14:0];
                    default:  r_std  <= r_std;
                endcase
            end
            if (r_out_valid && !i_out_stall && (r_state != S_EOUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        if (r_pending) begin
                            r_pending <= 1'b0;
                            r_y       <= r_stored;
                            r_state   <= S_EMUL;
                        end else begin
                            r_state <= S_SQA;
                        end
                    end
                end
                S_SQA: begin
                    r_w     <= prod[2*W-1:0];
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_w     <= r_w + prod[2*W-1:0];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if ((r_w == '0) || (r_w[2*W-1:FW] != 2'b00)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_norm  <= r_w[FW-1:0];
                        r_k     <= KW'(1);
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_norm[FW-1]) begin
                        r_m     <= norm_ext[FW+31 -: 32];
                        r_z     <= norm_ext[FW+31 -: 32];
                        r_frac  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_LOG;
                    end else begin
                        r_norm <= {r_norm[FW-2:0], 1'b0};
                        r_k    <= r_k + 1'b1;
                    end
                end
                S_LOG: begin
                    r_frac <= {r_frac[LOG_BITS-2:0], z_t[32]};
                    r_z    <= z_t[32] ? z_t[32:1] : z_t[31:0];
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 5'(LOG_BITS - 1)) begin
                        r_state <= S_LN;
                    end
                end
                S_LN: begin
                    r_rem   <= {2'b00, prod[61:31]};
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (rem2 >= 34'(r_m)) begin
                        r_rem <= 33'(rem2 - 34'(r_m));
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_rem <= rem2[32:0];
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd30) begin
                        r_state <= S_RST;
                    end
                end
                S_RST: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (sq_done) begin
                        r_s     <= sq_root;
                        r_k     <= k_adj;
                        r_state <= S_SCA;
                    end
                end
                S_SCA: begin
                    r_mag   <= prod[MW-1:0];
                    r_state <= S_SHA;
                end
                S_SHA: begin
                    r_y     <= y_sc;
                    r_state <= S_SCB;
                end
                S_SCB: begin
                    r_mag   <= prod[MW-1:0];
                    r_state <= S_SHB;
                end
                S_SHB: begin
                    r_stored  <= y_sc;
                    r_pending <= 1'b1;
                    r_state   <= S_EMUL;
                end
                S_EMUL: begin
                    r_emag  <= prod[37:0];
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    if (out_free) begin
                        r_sample    <= e_sat;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_neg <= i_uniform_a[W-1];
            r_b_neg <= i_uniform_b[W-1];
            r_a_mag <= i_uniform_a[W-1] ? a_neg_v[W-1:0] : i_uniform_a;
            r_b_mag <= i_uniform_b[W-1] ? b_neg_v[W-1:0] : i_uniform_b;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MEAN: prdata = {{16{r_mean[15]}}, r_mean};
            REG_STD:  prdata = {17'd0, r_std};
            default:  prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

endmodule

@@ hw/rtl/polgv_isqrt.sv @@
// Bit-serial integer square root, two operand bits per cycle.
module polgv_isqrt
    import polgv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SQ_OP_W-1:0]   i_operand,
    output logic                 o_done,
    output logic [SQ_ROOT_W-1:0] o_root
);

    logic [SQ_OP_W-1:0]   r_op;
    logic [SQ_REM_W-1:0]  r_rem;
    logic [SQ_ROOT_W-1:0] r_root;
    logic [SQ_CNT_W-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [SQ_REM_W+1:0]  rem_t;
    logic [SQ_REM_W+1:0]  trial;
    logic [SQ_REM_W+1:0]  diff;
    logic                 take;

    always_comb begin
        rem_t = {r_rem, r_op[SQ_OP_W-1 -: 2]};
        trial = (SQ_REM_W+2)'({r_root, 2'b01});
        take  = rem_t >= trial;
        diff  = rem_t - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SQ_CNT_W'(SQ_ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_operand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_op <= {r_op[SQ_OP_W-3:0], 2'b00};
            if (take) begin
                r_rem  <= diff[SQ_REM_W-1:0];
                r_root <= {r_root[SQ_ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_t[SQ_REM_W-1:0];
                r_root <= {r_root[SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
